// ===== src/rss_psc_pkg.sv =====
// shared constants, types and helpers for the rss pair safety check
package rss_psc_pkg;

   // configuration register file
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);
   localparam int CSR_IDX_W = REG_IDX_W + 1;
   localparam int REG_W     = 16;

   // register indexes
   localparam int REG_RESPONSE_TIME = 0;
   localparam int REG_LON_ACCEL_MAX = 1;
   localparam int REG_LON_BRAKE_MIN = 2;
   localparam int REG_LON_BRAKE_MAX = 3;
   localparam int REG_LAT_ACCEL_MAX = 4;
   localparam int REG_LAT_BRAKE_MIN = 5;
   localparam int REG_LAT_BRAKE_MAX = 6;
   localparam int REG_LAT_MARGIN    = 7;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] =
      '{16'd512, 16'd512, 16'd1024, 16'd2048, 16'd51, 16'd205, 16'd410, 16'd26};

   // field and datapath widths
   localparam int POS_W      = 32;
   localparam int VEL_W      = 20;
   localparam int MAG_W      = 20;
   localparam int GAP_W      = 33;
   localparam int NUM_W      = 45;
   localparam int DEN_W      = 17;
   localparam int T1_W       = 29;
   localparam int TERM_W     = 46;
   localparam int DIST_W     = 48;
   localparam int OUT_W      = 32;
   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 72;

   // term pipeline: four front stages, one divider stage per quotient bit, one sum stage
   localparam int TERM_PRE   = 4;
   localparam int DIV_STAGES = NUM_W;
   localparam int TERM_LAT   = TERM_PRE + DIV_STAGES + 1;

   // request for one distance term
   typedef struct packed {
      logic             passive;
      logic [MAG_W-1:0] speed;
   } term_req_type;

   // braking value of zero behaves as one
   function automatic logic [REG_W-1:0] brake_nz(input logic [REG_W-1:0] b);
      logic [REG_W-1:0] r;
      r = (b == '0) ? REG_W'(1) : b;
      return r;
   endfunction

endpackage

// ===== src/rss_pair_safety_check_unit.sv =====
// top level of the rss pair safety check pipeline
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata: ego and other positions and velocities
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: pair_safe and the two safe distances
//  csr      in   csr_valid/csr_ready    csr_index, csr_data: register write
//
// one request per cycle while no result is stalled; rsp_tvalid rises once the request has passed
// decode, the term pipeline and the combine stage, mostly the 45 radix-2 divider stages of each term
// reset clears all valid bits and loads the register defaults
// a stalled result freezes the whole pipeline and holds req_tready low
// csr writes are taken every cycle
module rss_pair_safety_check_unit
   import rss_psc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ego_s_pos, ego_d_pos, ego_s_vel, ego_d_vel,
   // other_s_pos, other_d_pos, other_s_vel, other_d_vel
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pair_safe, safe_lon_distance, safe_lat_distance, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_data
);

   typedef struct packed {
      logic [GAP_W-1:0] gap_s;
      logic [GAP_W-1:0] gap_d;
      logic             lon_zero;
      logic             lon_add;
      logic             lat_zero;
      logic             lat_add;
   } sb_type;

   logic [REG_W-1:0]      cfg_ff [NUM_REGS];
   logic                  en;

   // stage 0: request register
   logic                  vld0_ff;
   logic [REQ_DATA_W-1:0] data0_ff;
   // stage 1: decode
   logic                  vld1_ff;
   sb_type                sb1_ff;
   term_req_type          lon1_ff, lon2_ff, lat1_ff, lat2_ff;
   // delay line beside the terms
   logic [TERM_LAT-1:0]   vld_line_ff;
   sb_type                sb_line_ff [TERM_LAT];
   // combine stage
   logic                  vldc_ff;
   logic [DIST_W-1:0]     lon_ff, lat_ff;
   logic [GAP_W-1:0]      gap_s_ff, gap_d_ff;
   // result register
   logic                  rsp_valid_ff;
   logic                  safe_ff;
   logic [OUT_W-1:0]      lon_out_ff, lat_out_ff;

   logic [TERM_W-1:0]     lon_t1, lon_t2, lat_t1, lat_t2;
   sb_type                sb1_in;
   term_req_type          lon1_in, lon2_in, lat1_in, lat2_in;
   logic [DIST_W-1:0]     lon_in, lat_in;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cfg_ff[i] <= REG_RESET[i];
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         cfg_ff[csr_index[REG_IDX_W-1:0]] <= csr_data;
      end
   end

   // whole pipeline moves unless a result waits
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // decode direction, gaps and term operands
   always_comb begin
      logic signed [POS_W-1:0] es, ed, os, od;
      logic [VEL_W-1:0]        evs, evd, ovs, ovd;
      logic [GAP_W-1:0]        ds, dd;
      logic [MAG_W-1:0]        ems, emd, oms, omd;
      logic                    rear, right, front, t1_ego;
      es  = data0_ff[31:0];
      ed  = data0_ff[63:32];
      evs = data0_ff[83:64];
      evd = data0_ff[103:84];
      os  = data0_ff[135:104];
      od  = data0_ff[167:136];
      ovs = data0_ff[187:168];
      ovd = data0_ff[207:188];
      rear  = es >= os;
      right = ed >= od;
      front = !rear;
      ds = {es[POS_W-1], es} - {os[POS_W-1], os};
      dd = {ed[POS_W-1], ed} - {od[POS_W-1], od};
      sb1_in.gap_s = ds[GAP_W-1] ? -ds : ds;
      sb1_in.gap_d = dd[GAP_W-1] ? -dd : dd;
      ems = evs[VEL_W-1] ? -evs : evs;
      emd = evd[VEL_W-1] ? -evd : evd;
      oms = ovs[VEL_W-1] ? -ovs : ovs;
      omd = ovd[VEL_W-1] ? -ovd : ovd;
      // longitudinal: follower passive against leader braking
      lon1_in.passive  = 1'b1;
      lon1_in.speed    = front ? ems : oms;
      lon2_in.passive  = front && ovs[VEL_W-1];
      lon2_in.speed    = front ? oms : ems;
      sb1_in.lon_add   = front && ovs[VEL_W-1];
      sb1_in.lon_zero  = evs[VEL_W-1] || (rear && ovs[VEL_W-1]);
      // lateral: first term passive, second active unless the lateral velocities differ in sign
      t1_ego           = right ? evd[VEL_W-1] : !evd[VEL_W-1];
      lat1_in.passive  = 1'b1;
      lat1_in.speed    = t1_ego ? emd : omd;
      lat2_in.passive  = evd[VEL_W-1] ^ ovd[VEL_W-1];
      lat2_in.speed    = t1_ego ? omd : emd;
      sb1_in.lat_add   = evd[VEL_W-1] ^ ovd[VEL_W-1];
      sb1_in.lat_zero  = right ? (!evd[VEL_W-1] && ovd[VEL_W-1])
                               : (evd[VEL_W-1] && !ovd[VEL_W-1]);
   end

   // distance terms
   rss_psc_term u_lon1 (
      .clock(clock), .en(en), .req(lon1_ff), .resp_time(cfg_ff[REG_RESPONSE_TIME]),
      .accel(cfg_ff[REG_LON_ACCEL_MAX]), .brake_min(cfg_ff[REG_LON_BRAKE_MIN]),
      .brake_max(cfg_ff[REG_LON_BRAKE_MAX]), .term(lon_t1));
   rss_psc_term u_lon2 (
      .clock(clock), .en(en), .req(lon2_ff), .resp_time(cfg_ff[REG_RESPONSE_TIME]),
      .accel(cfg_ff[REG_LON_ACCEL_MAX]), .brake_min(cfg_ff[REG_LON_BRAKE_MIN]),
      .brake_max(cfg_ff[REG_LON_BRAKE_MAX]), .term(lon_t2));
   rss_psc_term u_lat1 (
      .clock(clock), .en(en), .req(lat1_ff), .resp_time(cfg_ff[REG_RESPONSE_TIME]),
      .accel(cfg_ff[REG_LAT_ACCEL_MAX]), .brake_min(cfg_ff[REG_LAT_BRAKE_MIN]),
      .brake_max(cfg_ff[REG_LAT_BRAKE_MAX]), .term(lat_t1));
   rss_psc_term u_lat2 (
      .clock(clock), .en(en), .req(lat2_ff), .resp_time(cfg_ff[REG_RESPONSE_TIME]),
      .accel(cfg_ff[REG_LAT_ACCEL_MAX]), .brake_min(cfg_ff[REG_LAT_BRAKE_MIN]),
      .brake_max(cfg_ff[REG_LAT_BRAKE_MAX]), .term(lat_t2));

   // combine two terms by sum or difference, clip negatives to zero, or force zero
   function automatic logic [DIST_W-1:0] combine(input logic [TERM_W-1:0] a,
                                                 input logic [TERM_W-1:0] b,
                                                 input logic zero, input logic add);
      logic [TERM_W:0]   sum;
      logic [TERM_W:0]   diff;
      logic [DIST_W-1:0] r;
      sum  = {1'b0, a} + {1'b0, b};
      diff = {1'b0, a} - {1'b0, b};
      if (zero)          r = '0;
      else if (add)      r = {1'b0, sum};
      else if (diff[TERM_W]) r = '0;
      else               r = {1'b0, diff};
      return r;
   endfunction

   always_comb begin
      sb_type sb;
      sb     = sb_line_ff[TERM_LAT-1];
      lon_in = combine(lon_t1, lon_t2, sb.lon_zero, sb.lon_add);
      lat_in = combine(lat_t1, lat_t2, sb.lat_zero, sb.lat_add)
             + {{(DIST_W-REG_W){1'b0}}, cfg_ff[REG_LAT_MARGIN]};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff      <= 1'b0;
         vld1_ff      <= 1'b0;
         vld_line_ff  <= '0;
         vldc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld0_ff      <= req_tvalid;
         vld1_ff      <= vld0_ff;
         vld_line_ff  <= {vld_line_ff[TERM_LAT-2:0], vld1_ff};
         vldc_ff      <= vld_line_ff[TERM_LAT-1];
         rsp_valid_ff <= vldc_ff;
      end
   end

   // payload path
   always_ff @(posedge clock) begin
      if (en) begin
         data0_ff <= req_tdata;
         sb1_ff   <= sb1_in;
         lon1_ff  <= lon1_in;
         lon2_ff  <= lon2_in;
         lat1_ff  <= lat1_in;
         lat2_ff  <= lat2_in;
         for (int i = 0; i < TERM_LAT; i++)
            sb_line_ff[i] <= (i == 0) ? sb1_ff : sb_line_ff[(i == 0) ? 0 : i - 1];
         lon_ff   <= lon_in;
         lat_ff   <= lat_in;
         gap_s_ff <= sb_line_ff[TERM_LAT-1].gap_s;
         gap_d_ff <= sb_line_ff[TERM_LAT-1].gap_d;
         // safety check on unsaturated distances, then saturate
         safe_ff    <= !(({{(DIST_W-GAP_W){1'b0}}, gap_s_ff} < lon_ff)
                      && ({{(DIST_W-GAP_W){1'b0}}, gap_d_ff} < lat_ff));
         lon_out_ff <= (|lon_ff[DIST_W-1:OUT_W]) ? '1 : lon_ff[OUT_W-1:0];
         lat_out_ff <= (|lat_ff[DIST_W-1:OUT_W]) ? '1 : lat_ff[OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1-2*OUT_W){1'b0}}, lat_out_ff, lon_out_ff, safe_ff};

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");
   a_unsafe_needs_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !safe_ff |-> lon_out_ff != '0 && lat_out_ff != '0)
      else $error("unsafe pair with a zero safe distance");
   a_line_frozen: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_line_ff))
      else $error("valid line moved during stall");
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vldc_ff))
      else $error("result valid without item in combine stage");
`endif

endmodule

// ===== src/rss_psc_term.sv =====
// one rss distance term: passive stopping distance or active braking distance
module rss_psc_term
   import rss_psc_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  term_req_type        req,
   input  logic [REG_W-1:0]    resp_time,
   input  logic [REG_W-1:0]    accel,
   input  logic [REG_W-1:0]    brake_min,
   input  logic [REG_W-1:0]    brake_max,
   output logic [TERM_W-1:0]   term
);

   // stage 1 registers
   logic [31:0]        at_ff;
   logic [29:0]        v10_ff;
   logic [39:0]        vv1_ff;
   logic               pas1_ff;
   logic [DEN_W-1:0]   den1_ff;
   // stage 2 registers
   logic [33:0]        w_ff;
   logic [34:0]        s_ff;
   logic [39:0]        vv2_ff;
   logic               pas2_ff;
   logic [DEN_W-1:0]   den2_ff;
   // stage 3 registers
   logic [33:0]        hh_ff;
   logic [33:0]        hl_ff;
   logic [33:0]        ll_ff;
   logic [50:0]        t1p_ff;
   logic [39:0]        vv3_ff;
   logic               pas3_ff;
   logic [DEN_W-1:0]   den3_ff;
   // stage 4 registers
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den4_ff;
   logic [T1_W-1:0]    t14_ff;
   // divider stages
   logic [DEN_W-1:0]   rem_ff [DIV_STAGES];
   logic [NUM_W-1:0]   nq_ff  [DIV_STAGES];
   logic [DEN_W-1:0]   dden_ff[DIV_STAGES];
   logic [T1_W-1:0]    dt1_ff [DIV_STAGES];
   logic [TERM_W-1:0]  term_ff;

   logic [33:0]        w_in;
   logic [34:0]        s_in;
   logic [16:0]        h_in;
   logic [16:0]        l_in;
   logic [67:0]        full_in;
   logic [NUM_W-1:0]   num_in;
   logic [T1_W-1:0]    t1_in;
   logic [DEN_W-1:0]   rem_in [DIV_STAGES];
   logic [NUM_W-1:0]   nq_in  [DIV_STAGES];

   // speed after response and the sum used by the response-time distance
   always_comb begin
      w_in = {4'b0, v10_ff} + {2'b0, at_ff};
      s_in = {5'b0, v10_ff} + {1'b0, w_in};
      h_in = w_ff[33:17];
      l_in = w_ff[16:0];
   end

   // square of w shifted down by 21, and operand select
   always_comb begin
      full_in = {hh_ff, 34'b0} + {16'b0, hl_ff, 18'b0} + {34'b0, ll_ff};
      num_in  = pas3_ff ? full_in[65:21] : {5'b0, vv3_ff};
      t1_in   = pas3_ff ? t1p_ff[49:21] : '0;
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         logic [DEN_W-1:0] src_rem;
         logic [NUM_W-1:0] src_nq;
         logic [DEN_W-1:0] src_den;
         logic [DEN_W:0]   cat;
         logic [DEN_W+1:0] diff;
         src_rem = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k - 1];
         src_nq  = (k == 0) ? num_ff : nq_ff[(k == 0) ? 0 : k - 1];
         src_den = (k == 0) ? den4_ff : dden_ff[(k == 0) ? 0 : k - 1];
         cat  = {src_rem, src_nq[NUM_W-1]};
         diff = {1'b0, cat} - {2'b0, src_den};
         if (!diff[DEN_W+1]) begin
            rem_in[k] = diff[DEN_W-1:0];
            nq_in[k]  = {src_nq[NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = cat[DEN_W-1:0];
            nq_in[k]  = {src_nq[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: products of inputs
         at_ff   <= accel * resp_time;
         v10_ff  <= {req.speed, 10'b0};
         vv1_ff  <= req.speed * req.speed;
         pas1_ff <= req.passive;
         den1_ff <= req.passive ? {1'b0, brake_nz(brake_min)} : {brake_nz(brake_max), 1'b0};
         // stage 2: adds
         w_ff    <= w_in;
         s_ff    <= s_in;
         vv2_ff  <= vv1_ff;
         pas2_ff <= pas1_ff;
         den2_ff <= den1_ff;
         // stage 3: partial products
         hh_ff   <= h_in * h_in;
         hl_ff   <= h_in * l_in;
         ll_ff   <= l_in * l_in;
         t1p_ff  <= s_ff * resp_time;
         vv3_ff  <= vv2_ff;
         pas3_ff <= pas2_ff;
         den3_ff <= den2_ff;
         // stage 4: numerator
         num_ff  <= num_in;
         den4_ff <= den3_ff;
         t14_ff  <= t1_in;
         // divider
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            dden_ff[k] <= (k == 0) ? den4_ff : dden_ff[(k == 0) ? 0 : k - 1];
            dt1_ff[k]  <= (k == 0) ? t14_ff : dt1_ff[(k == 0) ? 0 : k - 1];
         end
         // final sum
         term_ff <= {{(TERM_W-T1_W){1'b0}}, dt1_ff[DIV_STAGES-1]}
                  + {1'b0, nq_ff[DIV_STAGES-1]};
      end
   end

   assign term = term_ff;

endmodule

// ===== tb/rss_pair_safety_check_unit_test.sv =====
// self-checking testbench for the rss pair safety check unit
module rss_pair_safety_check_unit_test;
   import rss_psc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one pair of agents
   typedef struct packed {
      logic signed [19:0] other_d_vel;
      logic signed [19:0] other_s_vel;
      logic signed [31:0] other_d_pos;
      logic signed [31:0] other_s_pos;
      logic signed [19:0] ego_d_vel;
      logic signed [19:0] ego_s_vel;
      logic signed [31:0] ego_d_pos;
      logic signed [31:0] ego_s_pos;
   } pair_type;

   // one safety verdict
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] lat_dist;
      logic [31:0] lon_dist;
      logic        pair_safe;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_data;

   logic [REG_W-1:0] limits [NUM_REGS];
   pair_type         pending_pairs [$];
   verdict_type      expected_verdicts [$];
   int               error_count;
   int               hold_cycles;
   bit               idle_enable;
   bit               send_hold;

   rss_pair_safety_check_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("rss_pair_safety_check_unit verification failed");
      $finish;
   end

   // report one mismatch
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // append a pair to the pending list
   task automatic queue_pair(input pair_type p);
      pending_pairs = {pending_pairs, p};
   endtask

   // stopping distance while braking hard
   function automatic longint active_gap(input longint v, input longint b);
      return (v * v) / (2 * b);
   endfunction

   // distance covered through response then gentle braking, 128 bit exact
   function automatic longint passive_gap(input longint v, input longint a, input longint t,
                                          input longint b);
      logic [127:0] w, t1, t2;
      w  = 128'(1024 * v) + 128'(a * t);
      t1 = ((128'(1024 * v) + w) * 128'(t)) >> 21;
      t2 = ((w * w) >> 21) / 128'(b);
      return longint'(t1 + t2);
   endfunction

   function automatic longint nz(input logic [REG_W-1:0] b);
      return (b == 0) ? 1 : longint'(b);
   endfunction

   function automatic longint clip32(input longint x);
      if (x > 64'sh0FFFF_FFFF) return 64'sh0FFFF_FFFF;
      return x;
   endfunction

   // expected verdict for one pair under the current limits
   function automatic verdict_type predict_verdict(input pair_type p);
      verdict_type r;
      longint t, la, lbn, lbx, ta, tbn, tbx, ea, oa, lon, lat, ep, op, eact, oact;
      longint es, os, ed, od, evs, ovs, evd, ovd, sgap, dgap;
      bit rear, right;
      t = limits[REG_RESPONSE_TIME];
      la = limits[REG_LON_ACCEL_MAX];
      lbn = nz(limits[REG_LON_BRAKE_MIN]);
      lbx = nz(limits[REG_LON_BRAKE_MAX]);
      ta = limits[REG_LAT_ACCEL_MAX];
      tbn = nz(limits[REG_LAT_BRAKE_MIN]);
      tbx = nz(limits[REG_LAT_BRAKE_MAX]);
      es = p.ego_s_pos; os = p.other_s_pos; ed = p.ego_d_pos; od = p.other_d_pos;
      evs = p.ego_s_vel; ovs = p.other_s_vel; evd = p.ego_d_vel; ovd = p.other_d_vel;
      rear = es >= os;
      right = ed >= od;
      lon = 0;
      ea = evs < 0 ? -evs : evs;
      oa = ovs < 0 ? -ovs : ovs;
      if (evs >= 0) begin
         if (!rear) begin
            if (ovs >= 0) lon = passive_gap(ea, la, t, lbn) - active_gap(oa, lbx);
            else lon = passive_gap(ea, la, t, lbn) + passive_gap(oa, la, t, lbn);
         end else if (ovs >= 0) begin
            lon = passive_gap(oa, la, t, lbn) - active_gap(ea, lbx);
         end
      end
      if (lon < 0) lon = 0;
      ea = evd < 0 ? -evd : evd;
      oa = ovd < 0 ? -ovd : ovd;
      ep = passive_gap(ea, ta, t, tbn);
      op = passive_gap(oa, ta, t, tbn);
      eact = active_gap(ea, tbx);
      oact = active_gap(oa, tbx);
      if (right) begin
         if (evd >= 0 && ovd >= 0) lat = op - eact;
         else if (evd >= 0) lat = 0;
         else if (ovd < 0) lat = ep - oact;
         else lat = ep + op;
      end else begin
         if (evd >= 0 && ovd >= 0) lat = ep - oact;
         else if (evd >= 0) lat = ep + op;
         else if (ovd < 0) lat = op - eact;
         else lat = 0;
      end
      if (lat < 0) lat = 0;
      lat += limits[REG_LAT_MARGIN];
      sgap = es - os; if (sgap < 0) sgap = -sgap;
      dgap = ed - od; if (dgap < 0) dgap = -dgap;
      r = '0;
      r.pair_safe = !(sgap < lon && dgap < lat);
      r.lon_dist = 32'(clip32(lon));
      r.lat_dist = 32'(clip32(lat));
      return r;
   endfunction

   function automatic logic [19:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return 20'h80000;
         1: return 20'h7FFFF;
         2: return 20'($urandom);
         default: return 20'($signed($urandom_range(0, 16000)) - 8000);
      endcase
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      longint span;
      p.ego_s_pos = $urandom;
      p.ego_d_pos = $urandom;
      p.ego_s_vel = rand_vel();
      p.ego_d_vel = rand_vel();
      p.other_s_vel = rand_vel();
      p.other_d_vel = rand_vel();
      // mostly nearby agents so both verdicts show up
      span = ($urandom_range(0, 3) == 0) ? 64'd2147483647 : longint'($urandom_range(0, 60000));
      p.other_s_pos = ($urandom_range(0, 3) == 0) ? $urandom
                      : 32'(longint'(p.ego_s_pos) + longint'($urandom_range(0, 2*span)) - span);
      p.other_d_pos = ($urandom_range(0, 3) == 0) ? $urandom
                      : 32'(longint'(p.ego_d_pos) + longint'($urandom_range(0, 2000)) - 1000);
      if ($urandom_range(0, 15) == 0) p.other_s_pos = p.ego_s_pos;
      if ($urandom_range(0, 15) == 0) p.other_d_pos = p.ego_d_pos;
      return p;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pairs.size() > 0 && !send_hold
             && !(idle_enable && $urandom_range(0, 99) < 37)) begin
            pair_type p;
            p = pending_pairs.pop_front();
            req_tdata <= p;
            req_tvalid <= 1'b1;
            expected_verdicts = {expected_verdicts, predict_verdict(p)};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result stall control
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_enable && $urandom_range(0, 99) < 37);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         verdict_type got, want;
         got = rsp_tdata;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = expected_verdicts.pop_front();
            if (got.pair_safe !== want.pair_safe)
               report_mismatch("pair_safe", got.pair_safe, want.pair_safe);
            if (got.lon_dist !== want.lon_dist)
               report_mismatch("lon_dist", got.lon_dist, want.lon_dist);
            if (got.lat_dist !== want.lat_dist)
               report_mismatch("lat_dist", got.lat_dist, want.lat_dist);
         end
      end
   end

   task automatic wait_drained();
      while (pending_pairs.size() > 0 || req_tvalid || expected_verdicts.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_limit(input int idx, input logic [REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < NUM_REGS) limits[idx] = value;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      pair_type p;
      logic [REG_W-1:0] v;
      error_count = 0;
      hold_cycles = 0;
      idle_enable = 1'b0;
      send_hold = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      for (int i = 0; i < NUM_REGS; i++) limits[i] = REG_RESET[i];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and every direction and sign case at reset limits
      for (int i = 0; i < 16; i++) begin
         p = '0;
         p.ego_s_vel = i[0] ? 20'sd2000 : -20'sd2000;
         p.other_s_vel = i[1] ? 20'sd1500 : -20'sd1500;
         p.ego_d_vel = i[0] ? 20'sd300 : -20'sd300;
         p.other_d_vel = i[1] ? 20'sd200 : -20'sd200;
         p.other_s_pos = i[2] ? 32'sd100 : -32'sd100;
         p.other_d_pos = i[3] ? 32'sd10 : -32'sd10;
         queue_pair(p);
      end
      p = '0;
      queue_pair(p);
      p = {20'h7FFFF, 20'h7FFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
           20'h80000, 20'h80000, 32'h80000000, 32'h80000000};
      queue_pair(p);
      p = {20'h80000, 20'h80000, 32'h80000000, 32'h80000000,
           20'h7FFFF, 20'h7FFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
      queue_pair(p);
      p = {20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
           20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
      queue_pair(p);
      wait_drained();

      // phases of limit settings: all ones, all zero, zero response time with unit limits, random; unknown index too
      for (int ph = 0; ph < 6; ph++) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            case (ph)
               0: v = 16'hFFFF;
               1: v = 16'h0000;
               2: v = (r == REG_RESPONSE_TIME) ? 16'd0 : 16'd1;
               default: v = REG_W'($urandom);
            endcase
            write_limit(r, v);
         end
         write_limit(NUM_REGS + ph % NUM_REGS, REG_W'($urandom));
         idle_enable = (ph != 1);
         for (int i = 0; i < 200; i++) queue_pair(rand_pair());
         if (ph == 3) hold_cycles <= 300;
         if (ph == 4) begin
            // sender pauses until everything is back, then resumes
            while (pending_pairs.size() > 100) @(posedge clock);
            send_hold = 1'b1;
            while (expected_verdicts.size() > 0 || req_tvalid) @(posedge clock);
            send_hold = 1'b0;
         end
         wait_drained();
      end

      if (error_count == 0)
         $display("rss_pair_safety_check_unit verification clean");
      else
         $display("rss_pair_safety_check_unit verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/rss_psc_pkg.sv
src/rss_psc_term.sv
src/rss_pair_safety_check_unit.sv
tb/rss_pair_safety_check_unit_test.sv
